@@ rtl/shpq_pkg.sv @@
// Package with shared constants for the skew heap priority queue.
`timescale 1ns / 1ps
`default_nettype none
package shpq_pkg;
    localparam int CAPACITY_DEF = 256;
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_PEEK   = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
endpackage
`default_nettype wire

@@ rtl/shpq_free_stack.sv @@
// Free node stack: a memory of node indexes with a fill pointer and a reset sweep.
`timescale 1ns / 1ps
`default_nettype none
module shpq_free_stack #(
    parameter int CAPACITY = shpq_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_pop,
    input  wire logic          i_push,
    input  wire logic [AW-1:0] i_push_index,
    output logic      [AW-1:0] o_top,
    output logic      [CW-1:0] o_count,
    output logic               o_ready
);
    logic [AW-1:0] r_mem [CAPACITY];
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_init;
    logic          r_busy;
    logic [AW-1:0] r_top;
    logic [AW-1:0] w_rd_addr;

    assign o_count = r_count;
    assign o_top   = r_top;
    assign o_ready = !r_busy;

    always_comb begin
        n_count = r_count;
        if (i_pop) begin
            n_count = r_count - CW'(1);
        end else if (i_push) begin
            n_count = r_count + CW'(1);
        end
    end

    // After the reset sweep entry i holds CAPACITY-1-i; the top is read ahead from the next count.
    assign w_rd_addr = AW'(n_count - CW'(1));

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[AW'(r_init)] <= AW'(CW'(CAPACITY - 1) - r_init);
        end else if (i_push) begin
            r_mem[AW'(r_count)] <= i_push_index;
        end
        if (i_push && !r_busy) begin
            r_top <= i_push_index;
        end else begin
            r_top <= r_mem[w_rd_addr];
        end
        if (!i_rst_n) begin
            r_count <= CW'(CAPACITY);
            r_init  <= '0;
            r_busy  <= 1'b1;
        end else if (r_busy) begin
            r_init <= r_init + CW'(1);
            if (r_init == CW'(CAPACITY - 1)) begin
                r_busy <= 1'b0;
                // Top of a full stack is index 0.
            end
        end else begin
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    ap_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY)) else $error("free count above capacity");
    ap_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0) else $error("pop from empty free stack");
    ap_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && i_push)) else $error("push and pop together");
`endif
endmodule
`default_nettype wire

@@ rtl/skew_heap_priority_queue_core.sv @@
// Top level of the skew heap priority queue with its merge sequencer and node memories.
//
// Channel | Dir | tdata (low bit up)                                   | tuser
// s_axis  | in  | symbol[7:0] weight[39:8]                             | command[1:0]
// m_axis  | out | symbol[7:0] weight[39:8] count[48:40] empty[49] pad  | status[1:0]
//
// After reset the free stack is refilled before any transaction is accepted. An insert walks
// the right spine, reading nodes on the way down and swapping children on the way back; a pop
// also frees the root, a peek only reads it and a rejected or unused command goes to the output.
// The single node memory port sets the pace. A stalled result holds in the output register.
`timescale 1ns / 1ps
`default_nettype none
module skew_heap_priority_queue_core #(
    parameter int CAPACITY = shpq_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // symbol, weight
    input  wire logic [1:0]  s_axis_tuser,   // command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // out_symbol, out_weight, entry_count, is_empty
    output logic [1:0]       m_axis_tuser    // status
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DEC   = 11'b00000000010,
        S_RD    = 11'b00000000100,
        S_CUR   = 11'b00000001000,
        S_OTH   = 11'b00000010000,
        S_CMP   = 11'b00000100000,
        S_UNW   = 11'b00001000000,
        S_UNW2  = 11'b00010000000,
        S_ROOT  = 11'b00100000000,
        S_DONE  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    localparam logic [CW-1:0] NONE = CW'(CAPACITY);

    t_state r_state;
    logic [7:0]  r_sym_m   [CAPACITY];
    logic [31:0] r_wt_m    [CAPACITY];
    logic [CW-1:0] r_left_m  [CAPACITY];
    logic [CW-1:0] r_right_m [CAPACITY];
    logic [AW-1:0] r_path_m  [CAPACITY];

    logic [1:0]  r_cmd;
    logic [7:0]  r_isym;
    logic [31:0] r_iwt;
    logic [CW-1:0] r_root, r_held, r_cur, r_other, r_slot, r_depth;
    logic        r_slot_root;
    logic [31:0] r_wcur;
    logic [CW-1:0] r_rr;
    logic [AW-1:0] r_pn;
    logic [1:0]  r_status;
    logic [7:0]  r_osym;
    logic [31:0] r_ow;

    logic          w_fs_pop, w_fs_push, w_fs_ready;
    logic [AW-1:0] w_fs_top, w_fs_pidx;
    logic [CW-1:0] w_fs_count;

    // One memory address drives the node field reads; the path memory has its own.
    logic [AW-1:0] r_addr;
    logic [AW-1:0] w_rd_addr;
    logic [7:0]    r_rd_sym;
    logic [31:0]   r_rd_wt;
    logic [CW-1:0] r_rd_l, r_rd_r;
    logic [AW-1:0] r_rd_p;

    shpq_free_stack #(.CAPACITY(CAPACITY)) u_free (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pop(w_fs_pop), .i_push(w_fs_push),
        .i_push_index(w_fs_pidx), .o_top(w_fs_top), .o_count(w_fs_count),
        .o_ready(w_fs_ready)
    );

    assign s_axis_tready = (r_state == S_IDLE) && w_fs_ready;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {6'd0, (r_held == '0), 9'(r_held), r_ow, r_osym};

    logic w_ins_ok, w_pop_ok;
    assign w_ins_ok = (r_held < NONE) && (w_fs_count != '0);
    assign w_pop_ok = (r_root != NONE) && (r_held != '0);
    assign w_fs_pop  = (r_state == S_DEC) && (r_cmd == shpq_pkg::CMD_INSERT) && w_ins_ok;
    assign w_fs_push = (r_state == S_DONE) && (r_cmd == shpq_pkg::CMD_POP)
                       && (w_fs_count < NONE);
    assign w_fs_pidx = r_pn;

    assign w_rd_addr = (r_state == S_UNW) ? r_rd_p : r_addr;

    always_ff @(posedge i_clk) begin
        r_rd_sym <= r_sym_m[w_rd_addr];
        r_rd_wt  <= r_wt_m[w_rd_addr];
        r_rd_l   <= r_left_m[w_rd_addr];
        r_rd_r   <= r_right_m[w_rd_addr];
        r_rd_p   <= r_path_m[AW'(r_depth - CW'(1))];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_root  <= NONE;
            r_held  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_cmd    <= s_axis_tuser;
                        r_isym   <= s_axis_tdata[7:0];
                        r_iwt    <= s_axis_tdata[39:8];
                        r_addr   <= AW'(r_root);
                        r_status <= shpq_pkg::ST_OK;
                        r_osym   <= '0;
                        r_ow     <= '0;
                        r_state  <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_depth     <= '0;
                    r_slot_root <= 1'b1;
                    if (r_cmd == shpq_pkg::CMD_INSERT) begin
                        if (!w_ins_ok) begin
                            r_status <= shpq_pkg::ST_FULL;
                            r_state  <= S_OUT;
                        end else begin
                            r_sym_m[w_fs_top]   <= r_isym;
                            r_wt_m[w_fs_top]    <= r_iwt;
                            r_left_m[w_fs_top]  <= NONE;
                            r_right_m[w_fs_top] <= NONE;
                            r_held  <= r_held + CW'(1);
                            r_cur   <= r_root;
                            r_other <= CW'(w_fs_top);
                            r_state <= S_CUR;
                        end
                    end else if (r_cmd == shpq_pkg::CMD_POP || r_cmd == shpq_pkg::CMD_PEEK) begin
                        if (!w_pop_ok) begin
                            r_status <= shpq_pkg::ST_EMPTY;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_RD: begin
                    r_osym <= r_rd_sym;
                    r_ow   <= r_rd_wt;
                    if (r_cmd == shpq_pkg::CMD_POP) begin
                        r_pn    <= AW'(r_root);
                        r_held  <= r_held - CW'(1);
                        r_cur   <= (r_rd_l < NONE) ? r_rd_l : NONE;
                        r_other <= (r_rd_r < NONE) ? r_rd_r : NONE;
                        r_root  <= (r_rd_l < NONE) ? r_rd_l : NONE;
                        r_state <= S_CUR;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_CUR: begin
                    // r_cur is the slot content; when it is empty the other tree is linked into the slot.
                    if (r_cur == NONE) begin
                        if (r_slot_root) begin
                            r_root <= r_other;
                        end else begin
                            r_right_m[AW'(r_slot)] <= r_other;
                        end
                        r_state <= (r_depth != '0) ? S_UNW : S_DONE;
                    end else if (r_other == NONE || r_depth == NONE) begin
                        r_state <= (r_depth != '0) ? S_UNW : S_DONE;
                    end else begin
                        r_addr  <= AW'(r_cur);
                        r_state <= S_OTH;
                    end
                end
                S_OTH: begin
                    r_addr  <= AW'(r_other);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_wcur  <= r_rd_wt;
                    r_rr    <= r_rd_r;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    // r_rd holds the other root now; r_wcur and r_rr the current one.
                    if (r_wcur >= r_rd_wt) begin
                        if (r_slot_root) begin
                            r_root <= r_other;
                        end else begin
                            r_right_m[AW'(r_slot)] <= r_other;
                        end
                        r_path_m[AW'(r_depth)] <= AW'(r_other);
                        r_slot  <= r_other;
                        r_cur   <= (r_rd_r < NONE) ? r_rd_r : NONE;
                        r_other <= r_cur;
                    end else begin
                        r_path_m[AW'(r_depth)] <= AW'(r_cur);
                        r_slot  <= r_cur;
                        r_cur   <= (r_rr < NONE) ? r_rr : NONE;
                    end
                    r_slot_root <= 1'b0;
                    r_depth     <= r_depth + CW'(1);
                    r_state     <= S_CUR;
                end
                S_UNW: begin
                    r_depth <= r_depth - CW'(1);
                    r_state <= S_UNW2;
                end
                S_UNW2: begin
                    // The spine node fetched in the previous cycle exchanges its children.
                    r_left_m[r_rd_p]  <= r_rd_r;
                    r_right_m[r_rd_p] <= r_rd_l;
                    r_state <= (r_depth != '0) ? S_UNW : S_DONE;
                end
                S_DONE: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    ap_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= NONE) else $error("held count above capacity");
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
    ap_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !s_axis_tready) else $error("accept while busy");
`endif
endmodule
`default_nettype wire
